// ===== hw/rtl/sbpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbpc_pkg;

    // Shadow bitmap geometry.
    localparam int WORD_BITS        = 32;
    localparam int GRANULE_BYTES    = 16;
    localparam int REGIONS          = 4;
    localparam int SHADOW_WORDS     = 4096;
    localparam int MAX_ACCESS_BYTES = 4096;

    // Port field widths.
    localparam int FUNC_W = 2;
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 13;
    localparam int IDX_W  = 12;
    localparam int BASE_W = 12;

    // Derived widths.
    localparam int WIDX_W     = $clog2(SHADOW_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int POS_W      = WIDX_W + BIT_W;
    localparam int GRAN_SHIFT = $clog2(GRANULE_BYTES);
    localparam int SLOT_W     = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int MAX_GRANS  = (MAX_ACCESS_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int CNT_W      = $clog2(MAX_GRANS + WORD_BITS + 1);

    // Function codes carried by an input word.
    localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WORD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REGION = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REGION,
        ST_SETUP,
        ST_READ,
        ST_TEST,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/shadow_bitmap_poison_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        input      s_valid / s_ready  func, addr, size, entry_index, word_data,
//                                         region_begin, region_end,
//                                         region_shadow_base, region_enable
// m_        output     m_valid / m_ready  poisoned, region_hit, past_region_end
//
// A write word updates its store at the accept edge and answers with an all-zero result;
// a check that misses every region passes the region search and then gives its result.
// A check that hits goes through setup and then a read and a test state for each of the W
// shadow words visited (1 to 9), as the read port is registered; the walk stops at the
// first word with a poisoned covered bit. Reset clears the control state and the valid
// bits only. A stalled result sits in the output register while one more word is processed.

module shadow_bitmap_poison_check (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [sbpc_pkg::FUNC_W-1:0]        s_func,
    input  wire  [sbpc_pkg::ADDR_W-1:0]        s_addr,
    input  wire  [sbpc_pkg::SIZE_W-1:0]        s_size,
    input  wire  [sbpc_pkg::IDX_W-1:0]         s_entry_index,
    input  wire  [sbpc_pkg::WORD_BITS-1:0]     s_word_data,
    input  wire  [sbpc_pkg::ADDR_W-1:0]        s_region_begin,
    input  wire  [sbpc_pkg::ADDR_W-1:0]        s_region_end,
    input  wire  [sbpc_pkg::BASE_W-1:0]        s_region_shadow_base,
    input  wire                                s_region_enable,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic                               m_poisoned,
    output logic                               m_region_hit,
    output logic                               m_past_region_end
);

    localparam int WB = sbpc_pkg::WORD_BITS;
    localparam int AW = sbpc_pkg::ADDR_W;

    // Region table: four slots, read in parallel during the region search.
    logic [AW-1:0]                 start_reg [sbpc_pkg::REGIONS];
    logic [AW-1:0]                 limit_reg [sbpc_pkg::REGIONS];
    logic [sbpc_pkg::BASE_W-1:0]   base_reg  [sbpc_pkg::REGIONS];
    logic [sbpc_pkg::REGIONS-1:0]  valid_reg;

    // Shadow bitmap memory with a registered read port.
    logic [WB-1:0] shadow_mem [sbpc_pkg::SHADOW_WORDS];
    logic [WB-1:0] rdata_reg;

    sbpc_pkg::state_t state_reg, state_next;

    // Latched check request.
    logic [AW-1:0]                addr_reg;
    logic [sbpc_pkg::SIZE_W-1:0]  size_reg;

    // Chosen region.
    logic [AW-1:0]                sel_start_reg;
    logic [AW-1:0]                sel_limit_reg;
    logic [sbpc_pkg::BASE_W-1:0]  sel_base_reg;

    // Bitmap walk: absolute bit position (already wrapped to the shadow size)
    // and the number of bits still to test.
    logic [sbpc_pkg::POS_W-1:0]   pos_reg;
    logic [sbpc_pkg::CNT_W-1:0]   left_reg;

    // Pending result fields and the output register.
    logic res_poison_reg, res_hit_reg, res_past_reg;
    logic m_valid_reg, m_poison_reg, m_hit_reg, m_past_reg;

    logic accept;
    logic out_free;
    logic [sbpc_pkg::SIZE_W-1:0] size_clamped;

    // Region search: the lowest valid slot that holds the address wins.
    logic                        search_hit;
    logic [sbpc_pkg::SLOT_W-1:0] search_slot;

    // Setup arithmetic.
    logic [AW-1:0]                offset;
    logic [sbpc_pkg::POS_W-1:0]   first_pos;
    logic                         past_end;
    logic [sbpc_pkg::SIZE_W:0]    size_round;
    logic [sbpc_pkg::CNT_W-1:0]   gran_count;

    // Word test unit, shared over every word of the walk.
    logic [sbpc_pkg::BIT_W-1:0]   bit_sel;
    logic [sbpc_pkg::BIT_W:0]     room;
    logic [sbpc_pkg::BIT_W:0]     take;
    logic [WB-1:0]                low_mask;
    logic [WB-1:0]                word_mask;
    logic                         word_hit;
    logic [sbpc_pkg::CNT_W-1:0]   left_after;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign size_clamped = (s_size > sbpc_pkg::SIZE_W'(sbpc_pkg::MAX_ACCESS_BYTES)) ?
                          sbpc_pkg::SIZE_W'(sbpc_pkg::MAX_ACCESS_BYTES) : s_size;

    always_comb begin
        search_hit  = 1'b0;
        search_slot = '0;
        for (int i = sbpc_pkg::REGIONS - 1; i >= 0; i--) begin
            if (valid_reg[i] && (addr_reg >= start_reg[i]) && (addr_reg < limit_reg[i])) begin
                search_hit  = 1'b1;
                search_slot = sbpc_pkg::SLOT_W'(i);
            end
        end
    end

    // The first bit is base * WORD_BITS plus the granule offset; only the bits
    // that address the shadow memory matter, which also gives the index wrap.
    assign offset     = addr_reg - sel_start_reg;
    assign first_pos  = {sel_base_reg[sbpc_pkg::WIDX_W-1:0], {sbpc_pkg::BIT_W{1'b0}}}
                        + offset[sbpc_pkg::GRAN_SHIFT +: sbpc_pkg::POS_W];
    assign past_end   = ({1'b0, addr_reg} + (AW + 1)'(size_reg)) > {1'b0, sel_limit_reg};
    assign size_round = {1'b0, size_reg} + (sbpc_pkg::SIZE_W + 1)'(sbpc_pkg::GRANULE_BYTES - 1);
    assign gran_count = (size_reg <= sbpc_pkg::SIZE_W'(sbpc_pkg::GRANULE_BYTES)) ?
                        sbpc_pkg::CNT_W'(1) :
                        sbpc_pkg::CNT_W'(size_round >> sbpc_pkg::GRAN_SHIFT);

    // Test the bits [bit_sel, bit_sel + take) of the current shadow word.
    assign bit_sel    = pos_reg[sbpc_pkg::BIT_W-1:0];
    assign room       = (sbpc_pkg::BIT_W + 1)'(WB) - {1'b0, bit_sel};
    assign take       = (left_reg < sbpc_pkg::CNT_W'(room)) ?
                        (sbpc_pkg::BIT_W + 1)'(left_reg) : room;
    assign low_mask   = ~({WB{1'b1}} << take);
    assign word_mask  = low_mask << bit_sel;
    assign word_hit   = (rdata_reg & word_mask) != '0;
    assign left_after = left_reg - sbpc_pkg::CNT_W'(take);

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            sbpc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = (s_func == sbpc_pkg::FUNC_CHECK) ?
                                 sbpc_pkg::ST_REGION : sbpc_pkg::ST_RESULT;
                end
            end
            sbpc_pkg::ST_REGION: begin
                state_next = search_hit ? sbpc_pkg::ST_SETUP : sbpc_pkg::ST_RESULT;
            end
            sbpc_pkg::ST_SETUP: begin
                state_next = sbpc_pkg::ST_READ;
            end
            sbpc_pkg::ST_READ: begin
                state_next = sbpc_pkg::ST_TEST;
            end
            sbpc_pkg::ST_TEST: begin
                if (word_hit || (left_after == '0)) begin
                    state_next = sbpc_pkg::ST_RESULT;
                end else begin
                    state_next = sbpc_pkg::ST_READ;
                end
            end
            sbpc_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = sbpc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbpc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Shadow memory: written on a shadow word write, read during the walk.
    always_ff @(posedge aclk) begin
        if (accept && (s_func == sbpc_pkg::FUNC_WORD) &&
            (32'(s_entry_index) < sbpc_pkg::SHADOW_WORDS)) begin
            shadow_mem[s_entry_index[sbpc_pkg::WIDX_W-1:0]] <= s_word_data;
        end
        if (state_reg == sbpc_pkg::ST_READ) begin
            rdata_reg <= shadow_mem[pos_reg[sbpc_pkg::POS_W-1:sbpc_pkg::BIT_W]];
        end
    end

    // Region table fields hold no reset; only the valid bits do.
    always_ff @(posedge aclk) begin
        if (accept && (s_func == sbpc_pkg::FUNC_REGION) &&
            (32'(s_entry_index) < sbpc_pkg::REGIONS)) begin
            start_reg[s_entry_index[sbpc_pkg::SLOT_W-1:0]] <= s_region_begin;
            limit_reg[s_entry_index[sbpc_pkg::SLOT_W-1:0]] <= s_region_end;
            base_reg[s_entry_index[sbpc_pkg::SLOT_W-1:0]]  <= s_region_shadow_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (accept && (s_func == sbpc_pkg::FUNC_REGION) &&
                     (32'(s_entry_index) < sbpc_pkg::REGIONS)) begin
            valid_reg[s_entry_index[sbpc_pkg::SLOT_W-1:0]] <= s_region_enable;
        end
    end

    // Datapath of the check.
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg       <= s_addr;
            size_reg       <= size_clamped;
            res_poison_reg <= 1'b0;
            res_hit_reg    <= 1'b0;
            res_past_reg   <= 1'b0;
        end
        if (state_reg == sbpc_pkg::ST_REGION) begin
            sel_start_reg <= start_reg[search_slot];
            sel_limit_reg <= limit_reg[search_slot];
            sel_base_reg  <= base_reg[search_slot];
        end
        if (state_reg == sbpc_pkg::ST_SETUP) begin
            pos_reg      <= first_pos;
            left_reg     <= gran_count;
            res_hit_reg  <= 1'b1;
            res_past_reg <= past_end;
        end
        if (state_reg == sbpc_pkg::ST_TEST) begin
            pos_reg  <= pos_reg + sbpc_pkg::POS_W'(take);
            left_reg <= left_after;
            if (word_hit) begin
                res_poison_reg <= 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == sbpc_pkg::ST_RESULT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == sbpc_pkg::ST_RESULT) && out_free) begin
            m_poison_reg <= res_poison_reg;
            m_hit_reg    <= res_hit_reg;
            m_past_reg   <= res_past_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_poisoned        = m_poison_reg;
    assign m_region_hit      = m_hit_reg;
    assign m_past_region_end = m_past_reg;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // The fourth function code has no name in the package. The block must ignore it.
    localparam logic [sbpc_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 300;
    // Once fewer than this many words are left to send, both sides stop idling.
    localparam int CALM_TAIL    = 60;
    // A check visits at most nine shadow words, plus overhead.
    localparam int DRAIN_CYCLES = 50;
    // Checks only ever reach a window of shadow words: the last WRAP_WORDS words and
    // the first LOW_WORDS, with bit positions wrapping from the top into the bottom.
    localparam int WRAP_WORDS   = 8;
    localparam int LOW_WORDS    = 64;
    // Random regions span at most SPAN_TOP bytes and their bitmaps start no higher
    // than word BASE_TOP, so the farthest bit a check can reach is in word 63.
    localparam int SPAN_TOP     = 8192;
    localparam int BASE_TOP     = 40;

    // One input word as the block sees it.
    typedef struct {
        logic [sbpc_pkg::FUNC_W-1:0]    func;
        logic [sbpc_pkg::ADDR_W-1:0]    addr;
        logic [sbpc_pkg::SIZE_W-1:0]    size;
        logic [sbpc_pkg::IDX_W-1:0]     idx;
        logic [sbpc_pkg::WORD_BITS-1:0] data;
        logic [sbpc_pkg::ADDR_W-1:0]    rgn_lo;
        logic [sbpc_pkg::ADDR_W-1:0]    rgn_hi;
        logic [sbpc_pkg::BASE_W-1:0]    rgn_base;
        logic                           rgn_en;
    } access_word_t;

    // One result word.
    typedef struct {
        bit poisoned;
        bit region_hit;
        bit past_end;
    } verdict_t;

    // All inputs of the block start at known values.
    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [sbpc_pkg::FUNC_W-1:0]    s_func = '0;
    logic [sbpc_pkg::ADDR_W-1:0]    s_addr = '0;
    logic [sbpc_pkg::SIZE_W-1:0]    s_size = '0;
    logic [sbpc_pkg::IDX_W-1:0]     s_entry_index = '0;
    logic [sbpc_pkg::WORD_BITS-1:0] s_word_data = '0;
    logic [sbpc_pkg::ADDR_W-1:0]    s_region_begin = '0;
    logic [sbpc_pkg::ADDR_W-1:0]    s_region_end = '0;
    logic [sbpc_pkg::BASE_W-1:0]    s_region_shadow_base = '0;
    logic                           s_region_enable = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic                           m_poisoned;
    logic                           m_region_hit;
    logic                           m_past_region_end;

    shadow_bitmap_poison_check dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_func               (s_func),
        .s_addr               (s_addr),
        .s_size               (s_size),
        .s_entry_index        (s_entry_index),
        .s_word_data          (s_word_data),
        .s_region_begin       (s_region_begin),
        .s_region_end         (s_region_end),
        .s_region_shadow_base (s_region_shadow_base),
        .s_region_enable      (s_region_enable),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_poisoned           (m_poisoned),
        .m_region_hit         (m_region_hit),
        .m_past_region_end    (m_past_region_end)
    );

    // ------------------------------------------------------------------
    // Predictor state. It mirrors the region table and the shadow memory
    // as the block should hold them after every accepted word. The valid
    // bits start cleared, which matches the block after reset.
    // ------------------------------------------------------------------
    logic [sbpc_pkg::ADDR_W-1:0]    model_lo     [sbpc_pkg::REGIONS];
    logic [sbpc_pkg::ADDR_W-1:0]    model_hi     [sbpc_pkg::REGIONS];
    logic [sbpc_pkg::BASE_W-1:0]    model_base   [sbpc_pkg::REGIONS];
    bit                             model_on     [sbpc_pkg::REGIONS];
    bit [sbpc_pkg::WORD_BITS-1:0]   model_shadow [sbpc_pkg::SHADOW_WORDS];

    // The stimulus generator keeps its own view of the regions so that it can
    // aim addresses into them while it fills the queue ahead of time.
    logic [sbpc_pkg::ADDR_W-1:0]    plan_lo [sbpc_pkg::REGIONS];
    logic [sbpc_pkg::ADDR_W-1:0]    plan_hi [sbpc_pkg::REGIONS];
    bit                             plan_on [sbpc_pkg::REGIONS];

    access_word_t pending[$];
    verdict_t     verdicts_due[$];
    access_word_t held;

    int  gap_left = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;
    int  faults = 0;
    int  results_seen = 0;
    int  cycle_count = 0;

    // Applies one accepted word to the mirrored state and works out its result.
    // Write words and the spare code always answer with all three flags low.
    function automatic verdict_t apply_word(access_word_t w);
        verdict_t                    v;
        int                          slot;
        longint unsigned             sz;
        longint unsigned             grans;
        longint unsigned             start_bit;
        longint unsigned             pos;
        logic [sbpc_pkg::ADDR_W-1:0] offset;
        v = '{default: 1'b0};
        slot = -1;
        case (w.func)
            sbpc_pkg::FUNC_WORD: begin
                if (w.idx < sbpc_pkg::SHADOW_WORDS)
                    model_shadow[w.idx] = w.data;
            end
            sbpc_pkg::FUNC_REGION: begin
                if (w.idx < sbpc_pkg::REGIONS) begin
                    model_lo[w.idx]   = w.rgn_lo;
                    model_hi[w.idx]   = w.rgn_hi;
                    model_base[w.idx] = w.rgn_base;
                    model_on[w.idx]   = w.rgn_en;
                end
            end
            sbpc_pkg::FUNC_CHECK: begin
                sz = (w.size > sbpc_pkg::MAX_ACCESS_BYTES) ?
                     sbpc_pkg::MAX_ACCESS_BYTES : w.size;
                // Walk downward so that the lowest matching slot is the one kept.
                for (int i = sbpc_pkg::REGIONS - 1; i >= 0; i--) begin
                    if (model_on[i] && w.addr >= model_lo[i] && w.addr < model_hi[i])
                        slot = i;
                end
                if (slot >= 0) begin
                    v.region_hit = 1'b1;
                    // The end test is done in wide arithmetic, so it never wraps.
                    v.past_end = (longint'(w.addr) + sz) > longint'(model_hi[slot]);
                    offset = w.addr - model_lo[slot];
                    grans = (sz <= sbpc_pkg::GRANULE_BYTES) ? 1 :
                            (sz + sbpc_pkg::GRANULE_BYTES - 1) / sbpc_pkg::GRANULE_BYTES;
                    start_bit = longint'(model_base[slot]) * sbpc_pkg::WORD_BITS
                              + longint'(offset) / sbpc_pkg::GRANULE_BYTES;
                    // Bit positions past the last shadow word wrap to the first.
                    for (longint unsigned k = 0; k < grans; k++) begin
                        pos = start_bit + k;
                        if (model_shadow[(pos / sbpc_pkg::WORD_BITS) % sbpc_pkg::SHADOW_WORDS]
                                        [pos % sbpc_pkg::WORD_BITS])
                            v.poisoned = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    // Every field starts random, so that fields a function code does not use
    // still carry noise the block has to ignore.
    function automatic access_word_t noise_word();
        access_word_t w;
        w.func     = FUNC_SPARE;
        w.addr     = $urandom;
        w.size     = sbpc_pkg::SIZE_W'($urandom);
        w.idx      = sbpc_pkg::IDX_W'($urandom);
        w.data     = sbpc_pkg::WORD_BITS'($urandom);
        w.rgn_lo   = $urandom;
        w.rgn_hi   = $urandom;
        w.rgn_base = sbpc_pkg::BASE_W'($urandom);
        w.rgn_en   = 1'($urandom);
        return w;
    endfunction

    task automatic queue_check(logic [sbpc_pkg::ADDR_W-1:0] a,
                               logic [sbpc_pkg::SIZE_W-1:0] n);
        access_word_t w;
        w = noise_word();
        w.func = sbpc_pkg::FUNC_CHECK;
        w.addr = a;
        w.size = n;
        pending.push_back(w);
    endtask

    task automatic queue_shadow(logic [sbpc_pkg::IDX_W-1:0] i,
                                logic [sbpc_pkg::WORD_BITS-1:0] d);
        access_word_t w;
        w = noise_word();
        w.func = sbpc_pkg::FUNC_WORD;
        w.idx  = i;
        w.data = d;
        pending.push_back(w);
    endtask

    task automatic queue_region(logic [sbpc_pkg::IDX_W-1:0] slot,
                                logic [sbpc_pkg::ADDR_W-1:0] lo,
                                logic [sbpc_pkg::ADDR_W-1:0] hi,
                                logic [sbpc_pkg::BASE_W-1:0] base,
                                logic en);
        access_word_t w;
        w = noise_word();
        w.func     = sbpc_pkg::FUNC_REGION;
        w.idx      = slot;
        w.rgn_lo   = lo;
        w.rgn_hi   = hi;
        w.rgn_base = base;
        w.rgn_en   = en;
        pending.push_back(w);
        if (slot < sbpc_pkg::REGIONS) begin
            plan_lo[slot] = lo;
            plan_hi[slot] = hi;
            plan_on[slot] = en;
        end
    endtask

    // Mostly clean shadow words, some with a single poisoned granule, a few dense.
    function automatic logic [sbpc_pkg::WORD_BITS-1:0] poison_pattern();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return '0;
        if (roll < 8)
            return sbpc_pkg::WORD_BITS'(1) << $urandom_range(0, sbpc_pkg::WORD_BITS - 1);
        if (roll < 9)
            return sbpc_pkg::WORD_BITS'($urandom);
        return '1;
    endfunction

    // Sizes lean small; a few exceed the maximum to exercise saturation.
    function automatic logic [sbpc_pkg::SIZE_W-1:0] access_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return sbpc_pkg::SIZE_W'($urandom_range(0, sbpc_pkg::GRANULE_BYTES));
        if (roll < 80)
            return sbpc_pkg::SIZE_W'($urandom_range(sbpc_pkg::GRANULE_BYTES + 1, 600));
        if (roll < 95)
            return sbpc_pkg::SIZE_W'($urandom_range(601, sbpc_pkg::MAX_ACCESS_BYTES));
        return sbpc_pkg::SIZE_W'($urandom_range(sbpc_pkg::MAX_ACCESS_BYTES + 1,
                                                (1 << sbpc_pkg::SIZE_W) - 1));
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and the cycle limit.
    // ------------------------------------------------------------------
    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver. A word is predicted at the edge where the block accepts it, so
    // the expectations line up with the order in which the block sees words.
    // Between words the driver may insert a random idle gap.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            calm    <= 1'b0;
        end else begin
            calm <= (pending.size() < CALM_TAIL);
            // Nothing may change while a word is offered and not yet taken.
            if (!(s_valid && !s_ready)) begin
                if (s_valid)
                    verdicts_due.push_back(apply_word(held));
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 3);
                    s_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    held = pending.pop_front();
                    s_valid              <= 1'b1;
                    s_func               <= held.func;
                    s_addr               <= held.addr;
                    s_size               <= held.size;
                    s_entry_index        <= held.idx;
                    s_word_data          <= held.data;
                    s_region_begin       <= held.rgn_lo;
                    s_region_end         <= held.rgn_hi;
                    s_region_shadow_base <= held.rgn_base;
                    s_region_enable      <= held.rgn_en;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each accepted result is compared with the oldest expectation.
    // The ready line stalls in random bursts, except near the end.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        verdict_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    if (faults < 10)
                        $display("result %0d arrived with nothing expected: %0b %0b %0b",
                                 results_seen, m_poisoned, m_region_hit, m_past_region_end);
                    faults++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_poisoned !== want.poisoned || m_region_hit !== want.region_hit ||
                        m_past_region_end !== want.past_end) begin
                        if (faults < 10)
                            $display({"result %0d mismatch: expected poisoned=%0b hit=%0b ",
                                      "past=%0b, got poisoned=%0b hit=%0b past=%0b"},
                                     results_seen, want.poisoned, want.region_hit,
                                     want.past_end, m_poisoned, m_region_hit,
                                     m_past_region_end);
                        faults++;
                    end
                end
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        access_word_t                   w;
        logic [sbpc_pkg::WORD_BITS-1:0] image [sbpc_pkg::SHADOW_WORDS];
        int                             live[$];
        int                             pick;
        int                             kind;
        int                             widx;
        longint unsigned                span;
        longint unsigned                off;
        logic [sbpc_pkg::ADDR_W-1:0]    lo;

        // With every region slot invalid, no check can hit anything.
        queue_check(32'h0000_0000, 13'd0);
        queue_check(32'hFFFF_FFFF, 13'h1FFF);
        // The spare function code with every field at its maximum.
        w = '{func: FUNC_SPARE, addr: '1, size: '1, idx: '1, data: '1,
              rgn_lo: '1, rgn_hi: '1, rgn_base: '1, rgn_en: 1'b1};
        pending.push_back(w);
        // Slot numbers past the table are dropped; the valid bits stay clear.
        queue_region(12'd4, 32'h0000_0000, 32'hFFFF_FFFF, 12'd0, 1'b1);
        queue_region(12'hFFF, 32'h0000_0000, 32'hFFFF_FFFF, 12'd0, 1'b1);
        queue_check(32'h0000_1000, 13'd16);

        // Every shadow word a check can reach is written before any valid region is set up.
        // Words 10 to 17 back the first directed region: its first granule,
        // granule 31 and its last granule are poisoned and the rest is clean.
        for (int i = 0; i < WRAP_WORDS + LOW_WORDS; i++) begin
            widx = (sbpc_pkg::SHADOW_WORDS - WRAP_WORDS + i) % sbpc_pkg::SHADOW_WORDS;
            image[widx] = poison_pattern();
        end
        for (int i = 10; i <= 17; i++)
            image[i] = '0;
        image[10] = 32'h8000_0001;
        image[17] = 32'h8000_0000;
        image[0]  = '1;
        for (int i = 0; i < WRAP_WORDS + LOW_WORDS; i++) begin
            widx = (sbpc_pkg::SHADOW_WORDS - WRAP_WORDS + i) % sbpc_pkg::SHADOW_WORDS;
            queue_shadow(sbpc_pkg::IDX_W'(widx), image[widx]);
        end

        // Slot 1 overlaps slot 0 and maps past the last shadow word; slot 2 sits
        // at the top of the address space; slot 3 is valid but empty.
        queue_region(12'd0, 32'h0000_1000, 32'h0000_2000, 12'd10, 1'b1);
        queue_region(12'd1, 32'h0000_1800, 32'h0000_3000, 12'd4090, 1'b1);
        queue_region(12'd2, 32'hFFFF_F000, 32'hFFFF_FFFF, 12'd4095, 1'b1);
        queue_region(12'd3, 32'h0000_9000, 32'h0000_8000, 12'd0, 1'b1);

        queue_check(32'h0000_1000, 13'd0);       // single poisoned granule
        queue_check(32'h0000_1010, 13'd17);      // two clean granules
        queue_check(32'h0000_1020, 13'd464);     // stops one granule short of bit 31
        queue_check(32'h0000_1020, 13'd465);     // reaches bit 31
        queue_check(32'h0000_1200, 13'd3568);    // many words, last granule not reached
        queue_check(32'h0000_1FF0, 13'd16);      // ends exactly at the region end
        queue_check(32'h0000_1FF0, 13'd17);      // runs one byte past the end
        queue_check(32'h0000_1000, 13'd8191);    // saturated to the maximum size
        queue_check(32'h0000_1800, 13'd32);      // overlap: the lower slot wins
        queue_check(32'h0000_2800, 13'd4096);    // shadow index wraps around
        queue_check(32'hFFFF_FFF0, 13'd4096);    // end test must not wrap
        queue_check(32'hFFFF_FFFF, 13'd1);       // the end address itself misses
        queue_check(32'h0000_8800, 13'd1);       // inside neither bound of slot 3
        queue_region(12'd3, 32'h0000_0000, 32'h0000_0100, 12'd0, 1'b0);
        queue_check(32'h0000_0050, 13'd1);       // disabled slot is skipped

        // Random part: mostly checks aimed into live regions, with region and
        // shadow rewrites mixed in, plus stray addresses and ignored words.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                live.delete();
                for (int i = 0; i < sbpc_pkg::REGIONS; i++) begin
                    if (plan_on[i] && plan_lo[i] < plan_hi[i])
                        live.push_back(i);
                end
                if (kind < 60 && live.size() != 0) begin
                    pick = live[$urandom_range(0, live.size() - 1)];
                    span = longint'(plan_hi[pick]) - longint'(plan_lo[pick]);
                    // A quarter of the aimed checks land near the region end.
                    if ($urandom_range(0, 3) == 0)
                        off = span - 1 - (longint'($urandom) % ((span < 4200) ? span : 4200));
                    else
                        off = {$urandom, $urandom} % span;
                    queue_check(sbpc_pkg::ADDR_W'(longint'(plan_lo[pick]) + off),
                                access_size());
                end else begin
                    queue_check($urandom, access_size());
                end
            end else if (kind < 82) begin
                queue_shadow(sbpc_pkg::IDX_W'(sbpc_pkg::SHADOW_WORDS - WRAP_WORDS +
                                              $urandom_range(0, WRAP_WORDS + LOW_WORDS - 1)),
                             poison_pattern());
            end else if (kind < 94) begin
                lo = $urandom;
                case ($urandom_range(0, 2))
                    0: span = $urandom_range(1, sbpc_pkg::GRANULE_BYTES - 1);
                    1: span = $urandom_range(sbpc_pkg::GRANULE_BYTES, 512);
                    default: span = $urandom_range(513, SPAN_TOP);
                endcase
                queue_region(sbpc_pkg::IDX_W'($urandom_range(0, sbpc_pkg::REGIONS - 1)), lo,
                             sbpc_pkg::ADDR_W'(longint'(lo) + span),
                             sbpc_pkg::BASE_W'(sbpc_pkg::SHADOW_WORDS - WRAP_WORDS +
                                               $urandom_range(0, WRAP_WORDS + BASE_TOP)),
                             $urandom_range(0, 6) != 0);
            end else if (kind < 97) begin
                queue_region(sbpc_pkg::IDX_W'($urandom_range(sbpc_pkg::REGIONS,
                                                              (1 << sbpc_pkg::IDX_W) - 1)),
                             $urandom, $urandom, sbpc_pkg::BASE_W'($urandom), 1'($urandom));
            end else begin
                pending.push_back(noise_word());
            end
        end

        // Sampling on the falling edge keeps this loop clear of the clocked blocks.
        while (pending.size() != 0 || s_valid || verdicts_due.size() != 0)
            @(negedge aclk);
        // Any stray result would show up within this window.
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (faults == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sbpc_pkg.sv
hw/rtl/shadow_bitmap_poison_check.sv
sim/testbench.sv
